>>> hdl/apr_pkg.sv
// Shared types and constants for the adaptive particle resampler.
package apr_pkg;

    localparam int PARTICLES = 64;
    localparam int IDX_W     = $clog2(PARTICLES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int W_W       = 16;
    localparam int TOT_W     = 22;
    localparam int AVG_W     = 17;
    localparam int R_W       = 17;
    localparam int DIVD_W    = 33;
    localparam int DIVS_W    = 17;
    localparam int DCNT_W    = 6;
    localparam int RN_W      = R_W + CNT_W;
    localparam int KT_W      = TOT_W + 4;
    localparam int RS_W      = TOT_W + 5;
    localparam int ACC_W     = 51;

    localparam logic [1:0] REG_ALPHA_SLOW   = 2'd0;
    localparam logic [1:0] REG_ALPHA_FAST   = 2'd1;
    localparam logic [1:0] REG_WEIGHT_FLOOR = 2'd2;

    localparam logic [R_W-1:0] R_ONE = 17'h10000;

    typedef struct packed {
        logic load;
        logic div_mean;
        logic take_mean;
        logic blend_mul;
        logic blend_upd;
        logic div_ratio;
        logic take_ratio;
        logic ratio_full;
        logic clr_j;
        logic prep1;
        logic prep2;
        logic mac;
        logic emit_draw;
        logic adv_i;
        logic emit_tmpl;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic slow_zero;
        logic r_zero;
        logic hit;
        logic i_done;
        logic j_done;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/apr_div.sv
// Restoring divider, one quotient bit per cycle.
module apr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [apr_pkg::DIVD_W-1:0]  dividend,
    input  logic [apr_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [apr_pkg::DIVD_W-1:0]  quotient
);
    import apr_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIVD_W-1:0]   quo_reg, quo_next;
    logic [DIVS_W-1:0]   rem_reg, rem_next;
    logic [DIVS_W-1:0]   dvs_reg, dvs_next;
    logic [DIVS_W:0]     trial;
    logic [DIVS_W:0]     diff;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVS_W])
            begin
                rem_next = diff[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/apr_ctrl.sv
// Sequencing state machine of the resampler.
module apr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           has_observations,
    input  logic           last,
    output logic           in_stall,
    input  apr_pkg::stat_t stat,
    output apr_pkg::cmd_t  cmd
);
    import apr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVM  = 4'd1;
    localparam logic [3:0] S_WAITM = 4'd2;
    localparam logic [3:0] S_BMUL  = 4'd3;
    localparam logic [3:0] S_BUPD  = 4'd4;
    localparam logic [3:0] S_CHKR  = 4'd5;
    localparam logic [3:0] S_WAITR = 4'd6;
    localparam logic [3:0] S_RZ    = 4'd7;
    localparam logic [3:0] S_PREP1 = 4'd8;
    localparam logic [3:0] S_PREP2 = 4'd9;
    localparam logic [3:0] S_RD    = 4'd10;
    localparam logic [3:0] S_MAC   = 4'd11;
    localparam logic [3:0] S_CMP   = 4'd12;
    localparam logic [3:0] S_TMPL  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept && last && has_observations)
                    state_next = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.div_mean = 1'b1;
                state_next   = S_WAITM;
            end
            S_WAITM:
            begin
                if (stat.div_done)
                begin
                    cmd.take_mean = 1'b1;
                    state_next    = S_BMUL;
                end
            end
            S_BMUL:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = S_BUPD;
            end
            S_BUPD:
            begin
                cmd.blend_upd = 1'b1;
                state_next    = S_CHKR;
            end
            S_CHKR:
            begin
                if (stat.slow_zero)
                begin
                    cmd.ratio_full = 1'b1;
                    state_next     = S_RZ;
                end
                else
                begin
                    cmd.div_ratio = 1'b1;
                    state_next    = S_WAITR;
                end
            end
            S_WAITR:
            begin
                if (stat.div_done)
                begin
                    cmd.take_ratio = 1'b1;
                    state_next     = S_RZ;
                end
            end
            S_RZ:
            begin
                cmd.clr_j  = 1'b1;
                state_next = stat.r_zero ? S_TMPL : S_PREP1;
            end
            S_PREP1:
            begin
                cmd.prep1  = 1'b1;
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                cmd.prep2  = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.hit)
                    cmd.emit_draw = stat.out_free;
                else
                begin
                    cmd.adv_i  = 1'b1;
                    state_next = stat.i_done ? S_TMPL : S_RD;
                end
            end
            S_TMPL:
            begin
                if (stat.j_done)
                    state_next = S_IDLE;
                else
                    cmd.emit_tmpl = stat.out_free;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/apr_dp.sv
// Datapath: weight store, averages, ratio, draw walk and result register.
module apr_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_index,
    input  logic [15:0]                  wr_data,
    input  logic [15:0]                  weight,
    input  logic [15:0]                  start_fraction,
    input  logic                         last,
    input  apr_pkg::cmd_t                cmd,
    output apr_pkg::stat_t               stat,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [5:0]                   slot,
    output logic [5:0]                   source,
    output logic                         from_template,
    output logic                         end_of_run
);
    import apr_pkg::*;

    logic [15:0]        alpha_slow_reg, alpha_fast_reg;
    logic [3:0]         floor_reg;
    logic [W_W-1:0]     mem [PARTICLES];
    logic [W_W-1:0]     rd_data_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TOT_W-1:0]   tot_reg, tot_next;
    logic               store;
    logic [CNT_W-1:0]   n_reg;
    logic [TOT_W-1:0]   run_tot_reg;
    logic [15:0]        start_reg;
    logic [TOT_W-1:0]   tot_eff;
    logic [AVG_W-1:0]   mean_reg, slow_reg, fast_reg;
    logic [32:0]        prod_s_reg, prod_f_reg;
    logic               up_s_reg, up_f_reg;
    logic [AVG_W-1:0]   diff_s, diff_f;
    logic [R_W-1:0]     r_reg;
    logic [RN_W-1:0]    rn_reg;
    logic [KT_W-1:0]    kt_reg;
    logic [RS_W-1:0]    rs_reg;
    logic [ACC_W-1:0]   rkt_reg, step_reg, lhs_reg, rhs_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  div_dvd, quot;
    logic [DIVS_W-1:0]  div_dvs;
    logic               ov_reg;
    logic [5:0]         slot_reg, source_reg;
    logic               tmpl_reg, end_reg;
    logic               j_last;

    assign store    = (cnt_reg < CNT_W'(PARTICLES));
    assign cnt_next = store ? cnt_reg + 1'b1 : cnt_reg;
    assign tot_next = store ? tot_reg + TOT_W'(weight) : tot_reg;
    assign tot_eff  = (run_tot_reg == '0) ? TOT_W'(32'h10000) : run_tot_reg;

    assign div_start = cmd.div_mean || cmd.div_ratio;
    assign div_dvd   = cmd.div_mean ? DIVD_W'(tot_eff) : {fast_reg, 16'h0000};
    assign div_dvs   = cmd.div_mean ? DIVS_W'(n_reg) : slow_reg;

    apr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quot)
    );

    assign diff_s = (mean_reg >= slow_reg) ? mean_reg - slow_reg : slow_reg - mean_reg;
    assign diff_f = (mean_reg >= fast_reg) ? mean_reg - fast_reg : fast_reg - mean_reg;
    assign j_last = (j_reg + 1'b1 == n_reg);

    assign stat.div_done  = div_done;
    assign stat.slow_zero = (slow_reg == '0);
    assign stat.r_zero    = (r_reg == '0);
    assign stat.hit       = (j_reg < n_reg) && (lhs_reg > rhs_reg);
    assign stat.i_done    = ({1'b0, i_reg} + 1'b1 == n_reg);
    assign stat.j_done    = (j_reg == n_reg);
    assign stat.out_free  = !ov_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load && store)
            mem[cnt_reg[IDX_W-1:0]] <= weight;
        rd_data_reg <= mem[i_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_slow_reg <= 16'd387;
            alpha_fast_reg <= 16'd393;
            floor_reg      <= 4'd4;
            cnt_reg        <= '0;
            tot_reg        <= '0;
            slow_reg       <= '0;
            fast_reg       <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_ALPHA_SLOW:   alpha_slow_reg <= wr_data;
                    REG_ALPHA_FAST:   alpha_fast_reg <= wr_data;
                    REG_WEIGHT_FLOOR: floor_reg      <= wr_data[3:0];
                    default:          ;
                endcase
            end
            if (cmd.load)
            begin
                cnt_reg <= last ? '0 : cnt_next;
                tot_reg <= last ? '0 : tot_next;
            end
            if (cmd.blend_upd)
            begin
                slow_reg <= up_s_reg ? slow_reg + AVG_W'(prod_s_reg >> 16)
                                     : slow_reg - AVG_W'((prod_s_reg + 33'd65535) >> 16);
                fast_reg <= up_f_reg ? fast_reg + AVG_W'(prod_f_reg >> 16)
                                     : fast_reg - AVG_W'((prod_f_reg + 33'd65535) >> 16);
            end
            if (cmd.emit_draw || cmd.emit_tmpl)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && last)
        begin
            n_reg       <= cnt_next;
            run_tot_reg <= tot_next;
            start_reg   <= start_fraction;
        end
        if (cmd.take_mean)
            mean_reg <= quot[AVG_W-1:0];
        if (cmd.blend_mul)
        begin
            prod_s_reg <= alpha_slow_reg * diff_s;
            prod_f_reg <= alpha_fast_reg * diff_f;
            up_s_reg   <= (mean_reg >= slow_reg);
            up_f_reg   <= (mean_reg >= fast_reg);
        end
        if (cmd.ratio_full)
            r_reg <= R_ONE;
        if (cmd.take_ratio)
            r_reg <= (quot > DIVD_W'(R_ONE)) ? R_ONE : quot[R_W-1:0];
        if (cmd.clr_j)
            j_reg <= '0;
        if (cmd.prep1)
        begin
            rn_reg <= r_reg * n_reg;
            kt_reg <= floor_reg * tot_eff;
            rs_reg <= tot_eff * (5'd1 + 5'(floor_reg));
        end
        if (cmd.prep2)
        begin
            rkt_reg  <= ACC_W'(r_reg) * ACC_W'(kt_reg);
            rhs_reg  <= ACC_W'(start_reg) * ACC_W'(rs_reg);
            step_reg <= ACC_W'({rs_reg, 16'h0000});
            lhs_reg  <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        if (cmd.mac)
            lhs_reg <= lhs_reg + ACC_W'(rn_reg) * ACC_W'(rd_data_reg) + rkt_reg;
        if (cmd.adv_i)
            i_reg <= i_reg + 1'b1;
        if (cmd.emit_draw)
        begin
            slot_reg   <= j_reg[5:0];
            source_reg <= 6'(i_reg);
            tmpl_reg   <= 1'b0;
            end_reg    <= j_last;
            j_reg      <= j_reg + 1'b1;
            rhs_reg    <= rhs_reg + step_reg;
        end
        if (cmd.emit_tmpl)
        begin
            slot_reg   <= j_reg[5:0];
            source_reg <= j_reg[5:0];
            tmpl_reg   <= 1'b1;
            end_reg    <= j_last;
            j_reg      <= j_reg + 1'b1;
        end
    end

    assign out_valid     = ov_reg;
    assign slot          = slot_reg;
    assign source        = source_reg;
    assign from_template = tmpl_reg;
    assign end_of_run    = end_reg;

endmodule

>>> hdl/adaptive_particle_resampler.sv
// Weights load at one transfer per cycle while the input is not stalled; the last transfer starts
// the run when it carries observations. A run sets up with two divisions on the shared divider
// (mean and ratio), only the mean one when the slow average is zero, then walks the stored weights
// (memory read, multiply-accumulate, compare) and emits one result per slot; output stalls hold
// the run. Input stalls from the last transfer until the last result of the run is emitted.
module adaptive_particle_resampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] weight,
    input  logic [15:0] start_fraction,
    input  logic        has_observations,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  slot,
    output logic [5:0]  source,
    output logic        from_template,
    output logic        end_of_run
);
    import apr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    apr_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .has_observations (has_observations),
        .last             (last),
        .in_stall         (in_stall),
        .stat             (stat),
        .cmd              (cmd)
    );

    apr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .weight         (weight),
        .start_fraction (start_fraction),
        .last           (last),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot           (slot),
        .source         (source),
        .from_template  (from_template),
        .end_of_run     (end_of_run)
    );

endmodule

>>> hdl/apr_checker.sv
// Port-level checks of the resampler and their binding.
module apr_props (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [5:0] slot,
    input logic [5:0] source,
    input logic       from_template,
    input logic       end_of_run
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot) && $stable(source))
        else $error("stalled result changed");

    a_tmpl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && from_template |-> source == slot)
        else $error("template slot source mismatch");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_run |-> in_stall)
        else $error("input open during a run");

    a_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !end_of_run |=> in_stall)
        else $error("run ended without final slot");
endmodule

bind adaptive_particle_resampler apr_props u_apr_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot          (slot),
    .source        (source),
    .from_template (from_template),
    .end_of_run    (end_of_run)
);

>>> verif/apr_checker.sv
// Scoreboard for the particle resampler: predicts slot assignments and compares each output transfer.
`timescale 1ns / 1ps
module apr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] weight,
    input  logic [15:0] start_fraction,
    input  logic        has_observations,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  slot,
    input  logic [5:0]  source,
    input  logic        from_template,
    input  logic        end_of_run,
    output int          errors,
    output int          pending
);
    import apr_pkg::*;

    typedef struct packed {
        logic [5:0] slot;
        logic [5:0] source;
        logic       tmpl;
        logic       eor;
    } assign_t;

    localparam int EXP_DEPTH = 256;

    assign_t         exp_q [EXP_DEPTH];
    logic [7:0]      exp_wr;
    logic [7:0]      exp_rd;
    int              exp_cnt;

    logic [15:0]     alpha_slow_r;
    logic [15:0]     alpha_fast_r;
    logic [3:0]      floor_k;
    logic [15:0]     wstore [PARTICLES];
    int unsigned     nload;
    logic [21:0]     wtot;
    longint unsigned avg_slow;
    longint unsigned avg_fast;

    function automatic longint unsigned blend_avg(longint unsigned avg, longint unsigned mean,
                                                  longint unsigned alpha);
        if (mean >= avg)
            return avg + ((alpha * (mean - avg)) >> 16);
        return avg - ((alpha * (avg - mean) + 65535) >> 16);
    endfunction

    task automatic push_slot(longint unsigned j, longint unsigned src, logic tmpl,
                             longint unsigned n);
        assign_t e;
        e.slot   = j[5:0];
        e.source = src[5:0];
        e.tmpl   = tmpl;
        e.eor    = (j + 1 == n);
        exp_q[exp_wr] = e;
        exp_wr = exp_wr + 8'd1;
        exp_cnt++;
    endtask

    task automatic close_set(logic [15:0] st, logic obs);
        longint unsigned n, tot, mean, r, k, s, lhs, rscale, i, j;
        n = nload;
        tot = wtot;
        nload = 0;
        wtot = '0;
        if (obs && n != 0)
        begin
            if (tot == 0)
                tot = 65536;
            mean = tot / n;
            avg_slow = blend_avg(avg_slow, mean, alpha_slow_r) & 64'hFFFF_FFFF;
            avg_fast = blend_avg(avg_fast, mean, alpha_fast_r) & 64'hFFFF_FFFF;
            if (avg_slow == 0)
                r = 65536;
            else
            begin
                r = (avg_fast << 16) / avg_slow;
                if (r > 65536)
                    r = 65536;
            end
            j = 0;
            if (r != 0)
            begin
                k = floor_k;
                rscale = tot * (1 + k);
                s = 0;
                for (i = 0; i < n; i++)
                begin
                    s += wstore[i];
                    lhs = r * (n * s + (i + 1) * k * tot);
                    while (j < n && lhs > (st + 65536 * j) * rscale)
                    begin
                        push_slot(j, i, 1'b0, n);
                        j++;
                    end
                end
            end
            for (; j < n; j++)
                push_slot(j, j, 1'b1, n);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        assign_t e;
        if (!rst_n)
        begin
            alpha_slow_r = 16'd387;
            alpha_fast_r = 16'd393;
            floor_k      = 4'd4;
            nload        = 0;
            wtot         = '0;
            avg_slow     = 0;
            avg_fast     = 0;
            errors       = 0;
            exp_wr       = '0;
            exp_rd       = '0;
            exp_cnt      = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_ALPHA_SLOW:   alpha_slow_r = wr_data;
                    REG_ALPHA_FAST:   alpha_fast_r = wr_data;
                    REG_WEIGHT_FLOOR: floor_k = wr_data[3:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (exp_cnt == 0)
                begin
                    $display("%0t: unexpected transfer slot %0d source %0d", $time, slot, source);
                    errors++;
                end
                else
                begin
                    e = exp_q[exp_rd];
                    exp_rd = exp_rd + 8'd1;
                    exp_cnt--;
                    if (slot !== e.slot || source !== e.source || from_template !== e.tmpl
                        || end_of_run !== e.eor)
                    begin
                        $display("%0t: mismatch expected slot %0d source %0d tmpl %0d end %0d",
                                 $time, e.slot, e.source, e.tmpl, e.eor);
                        $display("%0t:          actual   slot %0d source %0d tmpl %0d end %0d",
                                 $time, slot, source, from_template, end_of_run);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (nload < PARTICLES)
                begin
                    wstore[nload] = weight;
                    wtot = wtot + weight;
                    nload++;
                end
                if (last)
                    close_set(start_fraction, has_observations);
            end
        end
        pending = exp_cnt;
    end

endmodule

>>> verif/testbench.sv
// Top-level testbench: drives weight sets and register writes, and reports the verdict.
`timescale 1ns / 1ps
module testbench;
    import apr_pkg::*;

    localparam int LIMIT  = 600000;
    localparam int SETTLE = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = REG_ALPHA_SLOW;
    logic [15:0] wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] weight = '0;
    logic [15:0] start_fraction = '0;
    logic        has_observations = 1'b0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  slot;
    logic [5:0]  source;
    logic        from_template;
    logic        end_of_run;
    int          errors;
    int          pending;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;
    int          items = 0;

    always #1 clk = ~clk;

    adaptive_particle_resampler u_dut (.*);
    apr_checker u_chk (.*);

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(logic [15:0] w, logic [15:0] st, logic obs, logic lst);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        weight           <= w;
        start_fraction   <= st;
        has_observations <= obs;
        last             <= lst;
        do
            @(posedge clk);
        while (in_stall);
        items++;
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_set(int n, logic obs);
        for (int i = 0; i < n; i++)
            send_item(rand_weight(), 16'($urandom_range(0, 65535)),
                      ($urandom_range(0, 1) == 1), (i == n - 1));
        send_item(rand_weight(), 16'($urandom_range(0, 65535)), obs, 1'b1);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] rand_alpha();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int target;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed sets
        write_reg(REG_WEIGHT_FLOOR, 16'd15);
        send_item(16'hFFFF, 16'h0000, 1'b1, 1'b1);
        send_item(16'h0000, 16'h0000, 1'b1, 1'b0);
        send_item(16'h0000, 16'hFFFF, 1'b1, 1'b1);
        send_item(16'h1234, 16'h8000, 1'b0, 1'b0);
        send_item(16'h4321, 16'h8000, 1'b0, 1'b1);
        settle();
        write_reg(REG_ALPHA_SLOW, 16'd1000);
        write_reg(REG_ALPHA_FAST, 16'hFFFF);
        write_reg(REG_WEIGHT_FLOOR, 16'd0);
        // drive fast average to zero: zero draw ratio
        send_item(16'd1, 16'h7FFF, 1'b1, 1'b0);
        send_item(16'd0, 16'h7FFF, 1'b1, 1'b1);
        send_item(16'hFFFF, 16'h0001, 1'b1, 1'b1);
        // overfull set
        for (int i = 0; i < 66; i++)
            send_item(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      1'b1, (i == 65));
        settle();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_ALPHA_SLOW, rand_alpha());
            write_reg(REG_ALPHA_FAST, rand_alpha());
            write_reg(REG_WEIGHT_FLOOR, (ph == 0) ? 16'd0 : (ph == 1) ? 16'd15
                                        : 16'($urandom_range(0, 15)));
            idle_pct  = (ph == 1 || ph == 3) ? 53 : 0;
            stall_pct = (ph == 2) ? 53 : 0;
            if (ph == 3)
            begin
                idle_pct  = 27;
                stall_pct = 27;
            end
            target = items + 20;
            while (items < target)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_set($urandom_range(0, 66), ($urandom_range(0, 4) != 0));
                else
                    send_set($urandom_range(0, 7), ($urandom_range(0, 4) != 0));
            end
            settle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
